>>> src/index_to_handle_hash_map_macros.svh
// Assertion macros for the index-to-handle hash map.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef INDEX_TO_HANDLE_HASH_MAP_MACROS_SVH
`define INDEX_TO_HANDLE_HASH_MAP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IHHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihhm assertion failed");

// next-cycle implication
`define IHHM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihhm assertion failed");

`else

`define IHHM_ASSERT_IMP(label, clk, rst, ante, cons)
`define IHHM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/ihhm_pkg.sv
// Shared constants and types for the index-to-handle hash map.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package ihhm_pkg;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 16;

   // table memory controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic vld_we;
      logic data_we;
   } ihhm_tbl_ctl_type;

endpackage

`default_nettype wire

>>> src/ihhm_req_if.sv
// Request channel: valid/ready with action, key, handle, handle_present.
// Depends on ihhm_pkg for field widths.
`default_nettype none

interface ihhm_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [ihhm_pkg::KEY_W-1:0]   key;
   logic [ihhm_pkg::HANDLE_W-1:0] handle;
   logic                         handle_present;

   modport source (output valid, action, key, handle, handle_present, input ready);
   modport sink   (input valid, action, key, handle, handle_present, output ready);
endinterface

`default_nettype wire

>>> src/ihhm_rsp_if.sv
// Response channel: valid/ready with found, found_handle, row_full.
// Depends on ihhm_pkg for field widths.
`default_nettype none

interface ihhm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [ihhm_pkg::HANDLE_W-1:0] found_handle;
   logic                          row_full;

   modport source (output valid, found, found_handle, row_full, input ready);
   modport sink   (input valid, found, found_handle, row_full, output ready);
endinterface

`default_nettype wire

>>> src/ihhm_row_sel.sv
// Row select: key modulo SETS. A mask for power-of-two SETS, otherwise a
// reciprocal multiply, a back-multiply and one correcting subtract.
// Depends on ihhm_pkg.
`default_nettype none

module ihhm_row_sel #(
   parameter int SETS = 256
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [ihhm_pkg::KEY_W-1:0]    key_in,
   output logic                         done,
   output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] row
);

   localparam int  ROW_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int  KW       = ihhm_pkg::KEY_W;
   localparam bit  POW2     = (SETS & (SETS - 1)) == 0;

   generate
      if (POW2) begin : g_mask
         if (SETS == 1) begin : g_one
            assign row = '0;
         end else begin : g_bits
            assign row = key_in[ROW_BITS-1:0];
         end
         assign done = start;
      end else begin : g_rem
         localparam int  TW = ROW_BITS + 1;
         localparam logic [TW-1:0] SETS_V = TW'(SETS);
         localparam logic [KW-1:0] RECIP  = KW'((64'd1 << KW) / 64'(SETS));

         logic                step_ff, step_in;
         logic [KW-1:0]       quot_ff, quot_in;
         logic [TW-1:0]       low_ff, low_in;
         logic [TW-1:0]       rem_ff, rem_in;
         logic [2*KW-1:0]     prod;
         logic [2*TW-1:0]     back;

         // quotient estimate is exact or one short, so the remainder is below 2*SETS
         assign prod = (2*KW)'(key_in) * (2*KW)'(RECIP);
         assign back = (2*TW)'(quot_ff[TW-1:0]) * (2*TW)'(SETS_V);

         always_comb begin
            step_in = start;
            quot_in = quot_ff;
            low_in  = low_ff;
            rem_in  = rem_ff;
            if (start) begin
               quot_in = prod[2*KW-1:KW];
               low_in  = key_in[TW-1:0];
            end
            if (step_ff) begin
               rem_in = low_ff - back[TW-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               step_ff <= 1'b0;
            end else begin
               step_ff <= step_in;
            end
            quot_ff <= quot_in;
            low_ff  <= low_in;
            rem_ff  <= rem_in;
         end

         assign done = step_ff;
         assign row  = (rem_ff >= SETS_V) ? ROW_BITS'(rem_ff - SETS_V) : ROW_BITS'(rem_ff);
      end
   endgenerate

endmodule

`default_nettype wire

>>> src/ihhm_table.sv
// Table memory: one row of way valid bits and one row of key/handle pairs
// per set, a single address, registered read. Depends on ihhm_pkg.
`default_nettype none

module ihhm_table #(
   parameter int SETS       = 256,
   parameter int WAYS       = 4,
   parameter int ENTRY_BITS = 48
) (
   input  wire                                          clock,
   input  wire  ihhm_pkg::ihhm_tbl_ctl_type             ctl,
   input  wire  [((SETS > 1) ? $clog2(SETS) : 1)-1:0]   addr,
   input  wire  [WAYS-1:0]                              wr_vld,
   input  wire  [WAYS-1:0][ENTRY_BITS-1:0]              wr_data,
   output logic [WAYS-1:0]                              rd_vld,
   output logic [WAYS-1:0][ENTRY_BITS-1:0]              rd_data
);

   logic [WAYS-1:0]                 vld_mem  [SETS];
   logic [WAYS-1:0][ENTRY_BITS-1:0] data_mem [SETS];
   logic [WAYS-1:0]                 rd_vld_ff;
   logic [WAYS-1:0][ENTRY_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.vld_we) begin
         vld_mem[addr] <= wr_vld;
      end
      if (ctl.data_we) begin
         data_mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_vld_ff  <= vld_mem[addr];
         rd_data_ff <= data_mem[addr];
      end
   end

   assign rd_vld  = rd_vld_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/index_to_handle_hash_map.sv
// Index-to-handle hash map: a SETS x WAYS set-associative table from a 32-bit
// key to a handle. The row is key modulo SETS; all ways of the row are compared
// at once. A get reports the stored handle; a set removes the key, reports the
// old handle and, with handle_present, stores the new pair in the lowest free
// way, flagging row_full when none is left. After reset a clearing pass over
// all SETS rows zeroes the valid bits, during which no request is taken. With
// power-of-two SETS the row read is issued at the transfer, then compare and
// write-back follow. Other SETS first pass through the MOD and READ states for
// the reciprocal-multiply remainder unit that picks the row. A finished response
// sits in an output register, and the next request is taken while it waits;
// write-back stalls only if the previous response is still not taken.
// Depends on ihhm_pkg, ihhm_req_if, ihhm_rsp_if, ihhm_row_sel, ihhm_table.
`default_nettype none
`include "index_to_handle_hash_map_macros.svh"

module index_to_handle_hash_map #(
   parameter int SETS        = 256,
   parameter int WAYS        = 4,
   parameter int HANDLE_BITS = 16
) (
   input wire         clock,
   input wire         reset,
   ihhm_req_if.sink   req_ch,
   ihhm_rsp_if.source rsp_ch
);

   localparam int ROW_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int KW       = ihhm_pkg::KEY_W;
   localparam int HW       = ihhm_pkg::HANDLE_W;
   localparam int HB       = HANDLE_BITS;
   localparam int EW       = KW + HB;
   localparam int WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam bit POW2     = (SETS & (SETS - 1)) == 0;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [ROW_BITS-1:0] clr_ff, clr_in;
   logic                action_ff;
   logic [KW-1:0]       key_ff;
   logic [HB-1:0]       handle_ff;
   logic                present_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [HW-1:0]       fhandle_ff, fhandle_in;
   logic                full_ff, full_in;

   logic                req_xfer;
   logic                cmp_go;
   logic                sel_start;
   logic                sel_done;
   logic [KW-1:0]       sel_key;
   logic [ROW_BITS-1:0] sel_row;

   ihhm_pkg::ihhm_tbl_ctl_type tbl_ctl;
   logic [ROW_BITS-1:0]        tbl_addr;
   logic [WAYS-1:0]            tbl_wr_vld;
   logic [WAYS-1:0][EW-1:0]    tbl_wr_data;
   logic [WAYS-1:0]            tbl_rd_vld;
   logic [WAYS-1:0][EW-1:0]    tbl_rd_data;

   logic [WAYS-1:0]     match;
   logic                hit;
   logic [WB-1:0]       hit_way;
   logic [WAYS-1:0]     vld_after;
   logic                has_free;
   logic [WB-1:0]       free_way;
   logic [HB-1:0]       old_handle;
   logic                do_store;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign cmp_go       = !rsp_valid_ff || rsp_ch.ready;

   assign sel_key   = (state_ff == ST_IDLE) ? req_ch.key : key_ff;
   assign sel_start = req_xfer && !POW2;

   ihhm_row_sel #(.SETS(SETS)) u_row_sel (
      .clock  (clock),
      .reset  (reset),
      .start  (sel_start),
      .key_in (sel_key),
      .done   (sel_done),
      .row    (sel_row)
   );

   // way compare, removal and free-way pick on the registered row
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      has_free   = 1'b0;
      free_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = tbl_rd_vld[w] && (tbl_rd_data[w][EW-1:HB] == key_ff);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WB'(w);
         end
      end
      old_handle = tbl_rd_data[hit_way][HB-1:0];
      vld_after  = tbl_rd_vld;
      if (hit) begin
         vld_after[hit_way] = 1'b0;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!vld_after[w]) begin
            has_free = 1'b1;
            free_way = WB'(w);
         end
      end
      do_store    = present_ff && has_free;
      tbl_wr_vld  = vld_after;
      tbl_wr_data = tbl_rd_data;
      if (do_store) begin
         tbl_wr_vld[free_way]  = 1'b1;
         tbl_wr_data[free_way] = {key_ff, handle_ff};
      end
      if (state_ff == ST_CLEAR) begin
         tbl_wr_vld = '0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      tbl_ctl.rd_en   = 1'b0;
      tbl_ctl.vld_we  = 1'b0;
      tbl_ctl.data_we = 1'b0;
      tbl_addr        = sel_row;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      found_in        = found_ff;
      fhandle_in      = fhandle_ff;
      full_in         = full_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            tbl_addr       = clr_ff;
            tbl_ctl.vld_we = 1'b1;
            clr_in         = clr_ff + ROW_BITS'(1);
            if (clr_ff == ROW_BITS'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (POW2) begin
                  tbl_ctl.rd_en = 1'b1;
                  state_in      = ST_CMP;
               end else begin
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            if (sel_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            tbl_ctl.rd_en = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (cmp_go) begin
               tbl_ctl.vld_we  = action_ff;
               tbl_ctl.data_we = action_ff && do_store;
               rsp_valid_in    = 1'b1;
               found_in        = hit;
               fhandle_in      = hit ? HW'(old_handle) : '0;
               full_in         = action_ff && present_ff && !has_free;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         action_ff  <= req_ch.action;
         key_ff     <= req_ch.key;
         handle_ff  <= HB'(req_ch.handle);
         present_ff <= req_ch.handle_present;
      end
      found_ff   <= found_in;
      fhandle_ff <= fhandle_in;
      full_ff    <= full_in;
   end

   ihhm_table #(.SETS(SETS), .WAYS(WAYS), .ENTRY_BITS(EW)) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .addr    (tbl_addr),
      .wr_vld  (tbl_wr_vld),
      .wr_data (tbl_wr_data),
      .rd_vld  (tbl_rd_vld),
      .rd_data (tbl_rd_data)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = found_ff;
   assign rsp_ch.found_handle = fhandle_ff;
   assign rsp_ch.row_full     = full_ff;

   // a removal frees a way, so a found key never gives a full row
   `IHHM_ASSERT_IMP(a_full_not_found, clock, reset, rsp_valid_ff && full_ff, !found_ff)
   `IHHM_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !found_ff, fhandle_ff == '0)
   `IHHM_ASSERT_NXT(a_cmp_rsp, clock, reset, (state_ff == ST_CMP) && cmp_go, rsp_valid_ff)
   `IHHM_ASSERT_IMP(a_no_wr_busy, clock, reset, req_xfer, !tbl_ctl.vld_we && !tbl_ctl.data_we)

endmodule

`default_nettype wire

>>> tb/sv/hash_map_tb_pkg.sv
// Testbench-side codes for the index-to-handle hash map checks.
// No dependencies; shared by the checker and the testbench top.
`timescale 1ns / 1ps

package hash_map_tb_pkg;

   typedef enum logic {
      MAP_GET = 1'b0,
      MAP_SET = 1'b1
   } map_action_type;

endpackage

>>> tb/sv/hash_map_checker.sv
// Checker for the index-to-handle hash map: watches both channels, keeps its own
// copy of the table, predicts each response and compares it field by field.
// Depends on ihhm_pkg, hash_map_tb_pkg, ihhm_req_if and ihhm_rsp_if.
`timescale 1ns / 1ps

module hash_map_checker #(
   parameter int SETS = 256,
   parameter int WAYS = 4
) (
   input  logic clock,
   input  logic reset,
   ihhm_req_if  req_ch,
   ihhm_rsp_if  rsp_ch,
   output int   failures,
   output int   in_flight
);

   typedef struct packed {
      logic                          found;
      logic [ihhm_pkg::HANDLE_W-1:0] found_handle;
      logic                          row_full;
   } map_result_type;

   logic                          slot_valid  [SETS*WAYS];
   logic [ihhm_pkg::KEY_W-1:0]    slot_key    [SETS*WAYS];
   logic [ihhm_pkg::HANDLE_W-1:0] slot_handle [SETS*WAYS];

   map_result_type expected_results [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      failures++;
   endtask

   function automatic map_result_type apply_map_access(
         input hash_map_tb_pkg::map_action_type act,
         input logic [ihhm_pkg::KEY_W-1:0]      key,
         input logic [ihhm_pkg::HANDLE_W-1:0]   handle,
         input logic                            present);
      map_result_type r;
      int             base;
      int             hit;
      int             free_way;
      r    = '0;
      base = int'(key % SETS) * WAYS;
      hit  = WAYS;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (slot_valid[base + w] && slot_key[base + w] == key) hit = w;
      end
      if (hit < WAYS) begin
         r.found        = 1'b1;
         r.found_handle = slot_handle[base + hit];
      end
      if (act == hash_map_tb_pkg::MAP_SET) begin
         if (hit < WAYS) slot_valid[base + hit] = 1'b0;
         if (present) begin
            free_way = WAYS;
            for (int w = WAYS - 1; w >= 0; w--) begin
               if (!slot_valid[base + w]) free_way = w;
            end
            if (free_way < WAYS) begin
               slot_valid[base + free_way]  = 1'b1;
               slot_key[base + free_way]    = key;
               slot_handle[base + free_way] = handle;
            end else begin
               r.row_full = 1'b1;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      map_result_type want;
      if (reset) begin
         failures = 0;
         expected_results.delete();
         for (int i = 0; i < SETS * WAYS; i++) slot_valid[i] = 1'b0;
      end else begin
         // response first: it always belongs to an earlier transfer
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.found !== want.found)
                  report_mismatch($sformatf("found: got %b, expected %b",
                                            rsp_ch.found, want.found));
               if (rsp_ch.found_handle !== want.found_handle)
                  report_mismatch($sformatf("found_handle: got %h, expected %h",
                                            rsp_ch.found_handle, want.found_handle));
               if (rsp_ch.row_full !== want.row_full)
                  report_mismatch($sformatf("row_full: got %b, expected %b",
                                            rsp_ch.row_full, want.row_full));
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(apply_map_access(
               hash_map_tb_pkg::map_action_type'(req_ch.action),
               req_ch.key, req_ch.handle, req_ch.handle_present));
      end
      in_flight <= expected_results.size();
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the hash map testbench: clock, reset, request and response traffic, verdict.
// Depends on ihhm_pkg, hash_map_tb_pkg, the channel interfaces, hash_map_checker
// and index_to_handle_hash_map.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 1000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 400;

   logic clock;
   logic reset;
   int   failures;
   int   in_flight;
   int   sent;
   int   cycle_count;

   logic [7:0]  row_pool   [6];
   logic [23:0] upper_pool [8];

   ihhm_req_if lookup_req ();
   ihhm_rsp_if lookup_rsp ();

   index_to_handle_hash_map i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (lookup_req),
      .rsp_ch (lookup_rsp)
   );

   hash_map_checker i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (lookup_req),
      .rsp_ch    (lookup_rsp),
      .failures  (failures),
      .in_flight (in_flight)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input hash_map_tb_pkg::map_action_type act,
                            input logic [ihhm_pkg::KEY_W-1:0] key,
                            input logic [ihhm_pkg::HANDLE_W-1:0] handle,
                            input logic present);
      int gap;
      // every third block of 64 transfers goes back to back
      gap = ((sent / 64) % 3 == 1) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         lookup_req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      lookup_req.valid          <= 1'b1;
      lookup_req.action         <= act;
      lookup_req.key            <= key;
      lookup_req.handle         <= handle;
      lookup_req.handle_present <= present;
      do @(posedge clock); while (!lookup_req.ready);
      sent++;
   endtask

   task automatic drain_results();
      lookup_req.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
   endtask

   task automatic send_random();
      logic [ihhm_pkg::KEY_W-1:0]      key;
      hash_map_tb_pkg::map_action_type act;
      // mostly a few crowded rows so that rows fill and keys hit
      if ($urandom_range(0, 9) == 0)
         key = $urandom;
      else
         key = {upper_pool[$urandom_range(0, 7)], row_pool[$urandom_range(0, 5)]};
      act = $urandom_range(0, 1) ? hash_map_tb_pkg::MAP_SET : hash_map_tb_pkg::MAP_GET;
      send_item(act, key, ihhm_pkg::HANDLE_W'($urandom), $urandom_range(0, 4) != 0);
   endtask

   // response side
   initial begin
      int stall;
      int taken;
      taken = 0;
      lookup_rsp.ready <= 1'b0;
      wait (reset === 1'b1);
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT)
            stall = HOLD_CYCLES;
         else
            stall = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            lookup_rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         lookup_rsp.ready <= 1'b1;
         do @(posedge clock); while (!lookup_rsp.valid);
         taken++;
      end
   end

   // request side and verdict
   initial begin
      logic [23:0] crowd;
      sent                      = 0;
      reset                     <= 1'b1;
      lookup_req.valid          <= 1'b0;
      lookup_req.action         <= hash_map_tb_pkg::MAP_GET;
      lookup_req.key            <= '0;
      lookup_req.handle         <= '0;
      lookup_req.handle_present <= 1'b0;
      row_pool[0]   = 8'h00;
      row_pool[1]   = 8'hFF;
      upper_pool[0] = 24'h000000;
      upper_pool[1] = 24'hFFFFFF;
      for (int i = 2; i < 6; i++) row_pool[i] = 8'($urandom);
      for (int i = 2; i < 8; i++) upper_pool[i] = 24'($urandom);
      crowd = 24'h5A5A00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table, zero handle, extreme keys and handles, replacement
      send_item(hash_map_tb_pkg::MAP_GET, 32'h0000_0000, 16'h0000, 1'b1);
      send_item(hash_map_tb_pkg::MAP_SET, 32'h0000_0000, 16'h0000, 1'b1);
      send_item(hash_map_tb_pkg::MAP_GET, 32'h0000_0000, 16'hFFFF, 1'b0);
      send_item(hash_map_tb_pkg::MAP_SET, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_item(hash_map_tb_pkg::MAP_GET, 32'hFFFF_FFFF, 16'h0000, 1'b1);
      send_item(hash_map_tb_pkg::MAP_SET, 32'hFFFF_FFFF, 16'h1234, 1'b1);
      // fill one row; the fifth store is dropped
      for (int i = 0; i < 5; i++)
         send_item(hash_map_tb_pkg::MAP_SET, {crowd + 24'(i), 8'h12},
                   16'hA000 + 16'(i), 1'b1);
      // full row, key present: the freed way takes the new pair
      send_item(hash_map_tb_pkg::MAP_SET, {crowd + 24'd2, 8'h12}, 16'hBEEF, 1'b1);
      send_item(hash_map_tb_pkg::MAP_GET, {crowd + 24'd2, 8'h12}, 16'h0000, 1'b0);
      send_item(hash_map_tb_pkg::MAP_SET, {crowd + 24'd4, 8'h12}, 16'h5555, 1'b1);
      // remove only, then the freed way is reused
      send_item(hash_map_tb_pkg::MAP_SET, {crowd + 24'd1, 8'h12}, 16'hFFFF, 1'b0);
      send_item(hash_map_tb_pkg::MAP_SET, {crowd + 24'd4, 8'h12}, 16'h5555, 1'b1);
      send_item(hash_map_tb_pkg::MAP_GET, {crowd + 24'd4, 8'h12}, 16'h0000, 1'b0);
      send_item(hash_map_tb_pkg::MAP_GET, {crowd + 24'd1, 8'h12}, 16'h0000, 1'b0);
      send_item(hash_map_tb_pkg::MAP_SET, 32'h7777_7712, 16'hAAAA, 1'b0);
      send_item(hash_map_tb_pkg::MAP_GET, {crowd, 8'h12}, 16'h0000, 1'b0);
      send_item(hash_map_tb_pkg::MAP_SET, 32'h8000_0012, 16'h8001, 1'b1);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain_results();
         send_random();
      end
      drain_results();
      repeat (16) @(posedge clock);

      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
